FILE: hw/rtl/kcl_pkg.sv
package kcl_pkg;

  // Default number of symbols in a code
  localparam int unsigned CodeLengthDef = 4;

  // Symbol encoding in the entry buffer: 0..9 digits, 10 star
  localparam int unsigned SymW = 4;

  localparam logic [3:0] KEY_STAR = 4'd9;
  localparam logic [3:0] KEY_ZERO = 4'd10;
  localparam logic [3:0] KEY_HASH = 4'd11;

  localparam logic [SymW-1:0] SYM_ZERO      = 4'd0;
  localparam logic [SymW-1:0] SYM_DIGIT_MAX = 4'd9;
  localparam logic [SymW-1:0] SYM_STAR      = 4'd10;

  localparam logic MODE_KEY  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  localparam logic [2:0] ERR_MAX = 3'd7;

  // Configuration register indexes
  localparam logic REG_LOCKOUT_TICKS = 1'b0;
  localparam logic REG_MAX_ERRORS    = 1'b1;

  localparam logic [15:0] LOCKOUT_TICKS_RST = 16'd5000;
  localparam logic [2:0]  MAX_ERRORS_RST    = 3'd3;

  typedef struct packed {
    logic        edit_mode;
    logic [2:0]  wrong_attempts;
    logic [15:0] lockout_remaining;
  } kcl_ctrl_t;

  typedef struct packed {
    logic       unlock;
    logic       wrong_code;
    logic       code_changed;
    logic       invalid_code;
    logic       locked_out;
    logic       editing;
    logic [2:0] error_count;
  } kcl_result_t;

endpackage

FILE: hw/rtl/kcl_if.sv
interface kcl_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [3:0] key_index;

  modport source (output valid, output mode, output key_index, input ready);
  modport sink   (input valid, input mode, input key_index, output ready);
endinterface

interface kcl_out_if;
  logic       valid;
  logic       ready;
  logic       unlock;
  logic       wrong_code;
  logic       code_changed;
  logic       invalid_code;
  logic       locked_out;
  logic       editing;
  logic [2:0] error_count;

  modport source (output valid, output unlock, output wrong_code, output code_changed,
                  output invalid_code, output locked_out, output editing,
                  output error_count, input ready);
  modport sink   (input valid, input unlock, input wrong_code, input code_changed,
                  input invalid_code, input locked_out, input editing,
                  input error_count, output ready);
endinterface

FILE: hw/rtl/keypad_code_lock.sv
// Keypad combination lock. Each input transfer is a key press (mode 0, key
// index in scan order: 0-8 digits 1-9, 9 star, 10 digit 0, 11 hash) or a time
// tick (mode 1); each one yields exactly one result transfer carrying event
// flags, edit mode and the wrong-attempt count. Throughput is one item per
// clock: the whole step is a single combinational pass from the state
// registers into the result register, and the input stays ready while the
// result register is empty or being drained, so the result is valid in the
// next cycle. Configuration (lockout length, error limit) is written via the
// plain write port; the user must do so while idle (the block does not check).
module keypad_code_lock
  import kcl_pkg::*;
#(
  parameter int unsigned CodeLength = CodeLengthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  kcl_in_if.sink      in_i,
  kcl_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int unsigned PosW = $clog2(CodeLength);

  // Lock state
  kcl_ctrl_t       ctrl_q, ctrl_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [SymW-1:0] entry_q [CodeLength];
  logic [SymW-1:0] entry_d [CodeLength];
  logic [SymW-1:0] code_q  [CodeLength];
  logic [SymW-1:0] code_d  [CodeLength];

  // Config registers
  logic [15:0] lockout_ticks_q;
  logic [2:0]  max_errors_q;

  // Result register
  kcl_result_t res_d, res_q;
  logic        out_valid_q;

  logic in_xfer;

  // Take a new item whenever the result slot is free or drains this cycle
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_xfer    = in_i.valid && in_i.ready;

  kcl_step #(
    .CodeLength(CodeLength)
  ) u_step (
    .mode_i         (in_i.mode),
    .key_index_i    (in_i.key_index),
    .ctrl_q_i       (ctrl_q),
    .pos_q_i        (pos_q),
    .entry_q_i      (entry_q),
    .code_q_i       (code_q),
    .lockout_ticks_i(lockout_ticks_q),
    .max_errors_i   (max_errors_q),
    .ctrl_d_o       (ctrl_d),
    .pos_d_o        (pos_d),
    .entry_d_o      (entry_d),
    .code_d_o       (code_d),
    .res_o          (res_d)
  );

  // State advances only on an input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
      pos_q  <= '0;
      for (int i = 0; i < CodeLength; i++) begin
        entry_q[i] <= SYM_ZERO;
        code_q[i]  <= SYM_ZERO;
      end
    end else if (in_xfer) begin
      ctrl_q  <= ctrl_d;
      pos_q   <= pos_d;
      entry_q <= entry_d;
      code_q  <= code_d;
    end
  end

  // Config writes; unused data bits are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lockout_ticks_q <= LOCKOUT_TICKS_RST;
      max_errors_q    <= MAX_ERRORS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_LOCKOUT_TICKS: lockout_ticks_q <= cfg_wdata_i;
        REG_MAX_ERRORS:    max_errors_q    <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  // Output slot: valid control is reset, payload is not
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.unlock       = res_q.unlock;
  assign out_o.wrong_code   = res_q.wrong_code;
  assign out_o.code_changed = res_q.code_changed;
  assign out_o.invalid_code = res_q.invalid_code;
  assign out_o.locked_out   = res_q.locked_out;
  assign out_o.editing      = res_q.editing;
  assign out_o.error_count  = res_q.error_count;

endmodule

FILE: hw/rtl/kcl_step.sv
// Next-state and result logic for one key press or tick.
module kcl_step
  import kcl_pkg::*;
#(
  parameter int unsigned CodeLength = CodeLengthDef,
  localparam int unsigned PosW = $clog2(CodeLength)
) (
  input  logic                 mode_i,
  input  logic [3:0]           key_index_i,
  input  kcl_ctrl_t            ctrl_q_i,
  input  logic [PosW-1:0]      pos_q_i,
  input  logic [SymW-1:0]      entry_q_i [CodeLength],
  input  logic [SymW-1:0]      code_q_i  [CodeLength],
  input  logic [15:0]          lockout_ticks_i,
  input  logic [2:0]           max_errors_i,
  output kcl_ctrl_t            ctrl_d_o,
  output logic [PosW-1:0]      pos_d_o,
  output logic [SymW-1:0]      entry_d_o [CodeLength],
  output logic [SymW-1:0]      code_d_o  [CodeLength],
  output kcl_result_t          res_o
);

  logic            same;
  logic            all_digits;
  logic [SymW-1:0] sym;
  logic [2:0]      errs_inc;
  logic [PosW-1:0] pos_next;

  always_comb begin
    same       = 1'b1;
    all_digits = 1'b1;
    for (int i = 0; i < CodeLength; i++) begin
      if (entry_q_i[i] != code_q_i[i]) same = 1'b0;
      if (entry_q_i[i] > SYM_DIGIT_MAX) all_digits = 1'b0;
    end
  end

  always_comb begin
    if (key_index_i < KEY_STAR) begin
      sym = key_index_i + 4'd1;
    end else if (key_index_i == KEY_ZERO) begin
      sym = SYM_ZERO;
    end else begin
      sym = SYM_STAR;
    end
  end

  assign errs_inc = (ctrl_q_i.wrong_attempts == ERR_MAX) ? ERR_MAX
                                                         : ctrl_q_i.wrong_attempts + 3'd1;
  assign pos_next = (pos_q_i == PosW'(CodeLength - 1)) ? '0 : pos_q_i + PosW'(1);

  always_comb begin
    ctrl_d_o  = ctrl_q_i;
    pos_d_o   = pos_q_i;
    entry_d_o = entry_q_i;
    code_d_o  = code_q_i;
    res_o     = '0;

    if (mode_i == MODE_TICK) begin
      if (ctrl_q_i.lockout_remaining != '0) begin
        ctrl_d_o.lockout_remaining = ctrl_q_i.lockout_remaining - 16'd1;
        if (ctrl_q_i.lockout_remaining == 16'd1) ctrl_d_o.wrong_attempts = '0;
      end
    end else if (ctrl_q_i.lockout_remaining != '0) begin
      res_o.locked_out = 1'b1;
    end else if (key_index_i <= KEY_HASH) begin
      if (!ctrl_q_i.edit_mode) begin
        if (key_index_i == KEY_HASH) begin
          ctrl_d_o.edit_mode = 1'b1;
          pos_d_o            = '0;
        end else if (key_index_i == KEY_STAR) begin
          pos_d_o = '0;
          if (same) begin
            res_o.unlock            = 1'b1;
            ctrl_d_o.wrong_attempts = '0;
            for (int i = 0; i < CodeLength; i++) entry_d_o[i] = SYM_ZERO;
          end else begin
            res_o.wrong_code        = 1'b1;
            ctrl_d_o.wrong_attempts = errs_inc;
            if (errs_inc >= max_errors_i) begin
              ctrl_d_o.lockout_remaining = lockout_ticks_i;
              // zero-length lockout: clear the count right away
              if (lockout_ticks_i == '0) ctrl_d_o.wrong_attempts = '0;
            end
          end
        end else begin
          entry_d_o[pos_q_i] = sym;
          pos_d_o            = pos_next;
        end
      end else begin
        if (key_index_i == KEY_HASH) begin
          pos_d_o = '0;
          if (all_digits) begin
            code_d_o           = entry_q_i;
            res_o.code_changed = 1'b1;
            ctrl_d_o.edit_mode = 1'b0;
          end else begin
            res_o.invalid_code = 1'b1;
          end
        end else begin
          entry_d_o[pos_q_i] = sym;
          pos_d_o            = pos_next;
        end
      end
    end

    res_o.editing     = ctrl_d_o.edit_mode;
    res_o.error_count = ctrl_d_o.wrong_attempts;
  end

endmodule

FILE: hw/rtl/kcl_checker.sv
module kcl_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       unlock_i,
  input logic       wrong_code_i,
  input logic       code_changed_i,
  input logic       invalid_code_i,
  input logic       locked_out_i,
  input logic       editing_i,
  input logic [2:0] error_count_i
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(error_count_i)
      && $stable(unlock_i) && $stable(editing_i))
    else $error("stalled result changed");

  // At most one event per result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> $onehot0({unlock_i, wrong_code_i, code_changed_i,
                              invalid_code_i, locked_out_i}))
    else $error("more than one event flag set");

  // Unlock clears the error count and happens outside edit mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && unlock_i |-> error_count_i == 3'd0 && !editing_i)
    else $error("unlock with errors pending or in edit mode");

  // Commit leaves edit mode, a refused commit stays in it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (code_changed_i || invalid_code_i) |-> editing_i == invalid_code_i)
    else $error("edit mode wrong after commit attempt");

endmodule

bind keypad_code_lock kcl_checker u_kcl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .unlock_i      (out_o.unlock),
  .wrong_code_i  (out_o.wrong_code),
  .code_changed_i(out_o.code_changed),
  .invalid_code_i(out_o.invalid_code),
  .locked_out_i  (out_o.locked_out),
  .editing_i     (out_o.editing),
  .error_count_i (out_o.error_count)
);
